// ===== hw/rtl/vmv_pkg.sv =====
// Shared types and constants for the voxel mean/variance block.
// No dependencies.
package vmv_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned IDX_W     = 12;
    localparam int unsigned VOXELS    = 4096;
    localparam int unsigned SUM_W     = 24;
    localparam int unsigned SQ_W      = 39;
    localparam int unsigned NCNT_W    = 9;
    localparam int unsigned VCNT_W    = 13;
    localparam int unsigned VOLCNT_W  = 8;
    localparam int unsigned PROD_W    = 48;
    localparam int unsigned NUM_W     = 64;
    localparam int unsigned DEN_W     = 16;
    localparam int unsigned ROOT_W    = 32;
    localparam int unsigned STEP_W    = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 13;

    localparam logic [NCNT_W-1:0] MIN_VOLUMES = 9'd2;
    localparam logic [NCNT_W-1:0] MAX_VOLUMES = 9'd256;
    localparam logic [VCNT_W-1:0] MAX_VOXELS  = 13'd4096;
    localparam logic [STEP_W-1:0] DIV_LAST    = 6'd63;
    localparam logic [STEP_W-1:0] SQRT_LAST   = 6'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME_COUNT = 2'd0,
        CFG_VOXEL_COUNT  = 2'd1,
        CFG_SPREAD_MODE  = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_DIFF,
        ST_DIVM,
        ST_LOADS,
        ST_DIVS,
        ST_SQL,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic acc;
        logic mul;
        logic diff;
        logic div_step;
        logic load_spread;
        logic sqrt_load;
        logic sqrt_step;
    } cmd_t;

    typedef struct packed {
        logic last_vol;
        logic mode;
    } sts_t;

endpackage

// ===== hw/rtl/vmv_datapath.sv =====
// Datapath: config registers, counters, accumulation memories, shared
// restoring divider and bit-pair square root. Depends on vmv_pkg.
module vmv_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vmv_pkg::cmd_t                   cmd,
    output vmv_pkg::sts_t                   sts,
    input  logic                            cfg_valid,
    input  logic [vmv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vmv_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic signed [vmv_pkg::SAMPLE_W-1:0] sample,
    output logic [vmv_pkg::IDX_W-1:0]       voxel_index,
    output logic signed [vmv_pkg::SUM_W-1:0] mean_value,
    output logic [vmv_pkg::SQ_W-1:0]        spread_value,
    output logic                            last_voxel
);

    logic [vmv_pkg::NCNT_W-1:0]   volume_count_reg;
    logic [vmv_pkg::VCNT_W-1:0]   voxel_count_reg;
    logic                         spread_mode_reg;
    logic [vmv_pkg::IDX_W-1:0]    voxel_cnt_reg;
    logic [vmv_pkg::VOLCNT_W-1:0] volume_cnt_reg;

    logic [vmv_pkg::SUM_W-1:0]    sum_mem [vmv_pkg::VOXELS];
    logic [vmv_pkg::SQ_W-1:0]     sq_mem  [vmv_pkg::VOXELS];
    logic [vmv_pkg::SUM_W-1:0]    rd_sum_reg;
    logic [vmv_pkg::SQ_W-1:0]     rd_sq_reg;

    logic signed [vmv_pkg::SAMPLE_W-1:0] sample_reg;
    logic [vmv_pkg::IDX_W-1:0]    idx_reg;
    logic                         first_reg, last_vol_reg, last_vox_reg;
    logic signed [vmv_pkg::SUM_W-1:0] sum_reg;
    logic [vmv_pkg::SQ_W-1:0]     sq_reg;
    logic [vmv_pkg::PROD_W-1:0]   nq_reg, ss_reg, d_reg;
    logic [vmv_pkg::DEN_W-1:0]    nd_reg;
    logic [vmv_pkg::NUM_W-1:0]    num_reg;
    logic [vmv_pkg::DEN_W-1:0]    den_reg;
    logic [vmv_pkg::DEN_W-1:0]    rem_reg;
    logic signed [vmv_pkg::SUM_W-1:0] mean_reg;
    logic [vmv_pkg::NUM_W-1:0]    x_reg;
    logic [vmv_pkg::ROOT_W+1:0]   srem_reg;
    logic [vmv_pkg::ROOT_W-1:0]   root_reg;

    logic [vmv_pkg::NCNT_W-1:0]   n_eff;
    logic [vmv_pkg::VCNT_W-1:0]   v_eff;
    logic                         last_vol, last_vox;
    logic [vmv_pkg::SAMPLE_W-1:0] mag;
    logic [2*vmv_pkg::SAMPLE_W-1:0] sq_term;
    logic signed [vmv_pkg::SUM_W-1:0] sum_next;
    logic [vmv_pkg::SQ_W-1:0]     sq_next;
    logic [vmv_pkg::SUM_W-1:0]    sum_abs;
    logic [vmv_pkg::DEN_W:0]      rem_sh;
    logic [vmv_pkg::DEN_W:0]      rem_diff;
    logic [vmv_pkg::ROOT_W+3:0]   srem_sh, trial;
    logic [vmv_pkg::NUM_W-1:0]    mean_q;

    always_comb
    begin
        n_eff = volume_count_reg;
        if (volume_count_reg < vmv_pkg::MIN_VOLUMES)
            n_eff = vmv_pkg::MIN_VOLUMES;
        else if (volume_count_reg > vmv_pkg::MAX_VOLUMES)
            n_eff = vmv_pkg::MAX_VOLUMES;
        v_eff = voxel_count_reg;
        if (voxel_count_reg == '0)
            v_eff = 13'd1;
        else if (voxel_count_reg > vmv_pkg::MAX_VOXELS)
            v_eff = vmv_pkg::MAX_VOXELS;
    end

    assign last_vol = {1'b0, volume_cnt_reg} >= (n_eff - 9'd1);
    assign last_vox = {1'b0, voxel_cnt_reg} >= (v_eff - 13'd1);

    assign mag      = sample_reg[vmv_pkg::SAMPLE_W-1] ? 16'(-sample_reg)
                                                      : 16'(sample_reg);
    assign sq_term  = mag * mag;
    assign sum_next = first_reg ? 24'(sample_reg)
                                : $signed(rd_sum_reg) + 24'(sample_reg);
    assign sq_next  = first_reg ? 39'(sq_term) : rd_sq_reg + 39'(sq_term);
    assign sum_abs  = sum_reg[vmv_pkg::SUM_W-1] ? 24'(-sum_reg) : 24'(sum_reg);

    // restoring divide, one quotient bit per cycle
    assign rem_sh   = {rem_reg, num_reg[vmv_pkg::NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign mean_q   = {num_reg[vmv_pkg::NUM_W-2:0], 1'b0};

    // square root, two radicand bits per cycle
    assign srem_sh  = {srem_reg, x_reg[vmv_pkg::NUM_W-1:vmv_pkg::NUM_W-2]};
    assign trial    = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_count_reg <= 9'd2;
            voxel_count_reg  <= 13'd4096;
            spread_mode_reg  <= 1'b0;
            voxel_cnt_reg    <= '0;
            volume_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (vmv_pkg::cfg_idx_t'(cfg_index))
                    vmv_pkg::CFG_VOLUME_COUNT: volume_count_reg <= cfg_data[8:0];
                    vmv_pkg::CFG_VOXEL_COUNT:  voxel_count_reg  <= cfg_data;
                    vmv_pkg::CFG_SPREAD_MODE:  spread_mode_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                if (last_vox)
                begin
                    voxel_cnt_reg  <= '0;
                    volume_cnt_reg <= last_vol ? '0 : volume_cnt_reg + 8'd1;
                end
                else
                    voxel_cnt_reg <= voxel_cnt_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_sum_reg <= sum_mem[voxel_cnt_reg];
            rd_sq_reg  <= sq_mem[voxel_cnt_reg];
        end
        if (cmd.acc)
        begin
            sum_mem[idx_reg] <= sum_next;
            sq_mem[idx_reg]  <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg   <= sample;
            idx_reg      <= voxel_cnt_reg;
            first_reg    <= volume_cnt_reg == '0;
            last_vol_reg <= last_vol;
            last_vox_reg <= last_vox;
        end
        if (cmd.acc)
        begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
        end
        if (cmd.mul)
        begin
            nq_reg <= 48'(n_eff) * 48'(sq_reg);
            ss_reg <= 48'(sum_abs) * 48'(sum_abs);
            nd_reg <= 16'(n_eff) * 16'(n_eff - 9'd1);
        end
        if (cmd.diff)
        begin
            d_reg   <= (nq_reg > ss_reg) ? nq_reg - ss_reg : '0;
            num_reg <= {32'd0, sum_abs, 8'd0};
            den_reg <= {7'd0, n_eff};
            rem_reg <= '0;
        end
        else if (cmd.load_spread)
        begin
            mean_reg <= sum_reg[vmv_pkg::SUM_W-1] ? 24'(-num_reg) : 24'(num_reg);
            num_reg  <= spread_mode_reg ? {d_reg, 16'd0} : {8'd0, d_reg, 8'd0};
            den_reg  <= nd_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[vmv_pkg::DEN_W])
            begin
                rem_reg <= rem_diff[vmv_pkg::DEN_W-1:0];
                num_reg <= mean_q | 64'd1;
            end
            else
            begin
                rem_reg <= rem_sh[vmv_pkg::DEN_W-1:0];
                num_reg <= mean_q;
            end
        end
        if (cmd.sqrt_load)
        begin
            x_reg    <= num_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            x_reg <= {x_reg[vmv_pkg::NUM_W-3:0], 2'b00};
            if (srem_sh >= trial)
            begin
                srem_reg <= 34'(srem_sh - trial);
                root_reg <= {root_reg[vmv_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh[vmv_pkg::ROOT_W+1:0];
                root_reg <= {root_reg[vmv_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign sts.last_vol = last_vol_reg;
    assign sts.mode     = spread_mode_reg;

    assign voxel_index  = idx_reg;
    assign mean_value   = mean_reg;
    assign last_voxel   = last_vox_reg;
    assign spread_value = spread_mode_reg ? {7'd0, root_reg}
                        : (num_reg[vmv_pkg::NUM_W-1:vmv_pkg::SQ_W] != '0)
                          ? {vmv_pkg::SQ_W{1'b1}} : num_reg[vmv_pkg::SQ_W-1:0];

endmodule

// ===== hw/rtl/vmv_ctrl.sv =====
// Controller FSM: sequences accumulate, multiply, divide and root steps.
// Depends on vmv_pkg.
module vmv_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  vmv_pkg::sts_t sts,
    output vmv_pkg::cmd_t cmd
);

    vmv_pkg::state_t             state_reg, state_next;
    logic [vmv_pkg::STEP_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            vmv_pkg::ST_IDLE:  if (in_valid) state_next = vmv_pkg::ST_ACC;
            vmv_pkg::ST_ACC:   state_next = sts.last_vol ? vmv_pkg::ST_MUL : vmv_pkg::ST_IDLE;
            vmv_pkg::ST_MUL:   state_next = vmv_pkg::ST_DIFF;
            vmv_pkg::ST_DIFF:
            begin
                state_next = vmv_pkg::ST_DIVM;
                cnt_next   = '0;
            end
            vmv_pkg::ST_DIVM:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == vmv_pkg::DIV_LAST) state_next = vmv_pkg::ST_LOADS;
            end
            vmv_pkg::ST_LOADS:
            begin
                state_next = vmv_pkg::ST_DIVS;
                cnt_next   = '0;
            end
            vmv_pkg::ST_DIVS:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == vmv_pkg::DIV_LAST)
                    state_next = sts.mode ? vmv_pkg::ST_SQL : vmv_pkg::ST_OUT;
            end
            vmv_pkg::ST_SQL:
            begin
                state_next = vmv_pkg::ST_SQRT;
                cnt_next   = '0;
            end
            vmv_pkg::ST_SQRT:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == vmv_pkg::SQRT_LAST) state_next = vmv_pkg::ST_OUT;
            end
            vmv_pkg::ST_OUT:   if (out_ready) state_next = vmv_pkg::ST_IDLE;
            default:           state_next = vmv_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            vmv_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            vmv_pkg::ST_ACC:   cmd.acc         = 1'b1;
            vmv_pkg::ST_MUL:   cmd.mul         = 1'b1;
            vmv_pkg::ST_DIFF:  cmd.diff        = 1'b1;
            vmv_pkg::ST_DIVM:  cmd.div_step    = 1'b1;
            vmv_pkg::ST_LOADS: cmd.load_spread = 1'b1;
            vmv_pkg::ST_DIVS:  cmd.div_step    = 1'b1;
            vmv_pkg::ST_SQL:   cmd.sqrt_load   = 1'b1;
            vmv_pkg::ST_SQRT:  cmd.sqrt_step   = 1'b1;
            vmv_pkg::ST_OUT:   out_valid       = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vmv_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTH
    a_accept_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == vmv_pkg::ST_ACC)
        else $error("accepted request not accumulated");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vmv_pkg::ST_DIVS && cnt_reg != vmv_pkg::DIV_LAST)
        |=> state_reg == vmv_pkg::ST_DIVS && cnt_reg == $past(cnt_reg) + 6'd1)
        else $error("divider step count broken");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
`endif

endmodule

// ===== hw/rtl/voxel_mean_variance.sv =====
// Per-voxel mean and variance / std deviation over a volume sequence.
// Non-final volumes only accumulate; the final volume also runs the
// bit-serial divider (64 steps, used twice) and, in mode 1, the 32-step
// root. One request in flight.
// Reset: async active low clears counters, FSM and config to defaults;
// accumulation memories are not cleared (first volume overwrites).
module voxel_mean_variance (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vmv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vmv_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vmv_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vmv_pkg::IDX_W-1:0]           voxel_index,
    output logic signed [vmv_pkg::SUM_W-1:0]    mean_value,
    output logic [vmv_pkg::SQ_W-1:0]            spread_value,
    output logic                                last_voxel
);

    vmv_pkg::cmd_t cmd;
    vmv_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    vmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vmv_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .voxel_index  (voxel_index),
        .mean_value   (mean_value),
        .spread_value (spread_value),
        .last_voxel   (last_voxel)
    );

endmodule
